// ----- rtl/core/kmds_pkg.sv -----
package kmds_pkg;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE_MS = 2'd0,
    CFG_ROWS_USED   = 2'd1,
    CFG_COLS_USED   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] row_levels;
    logic [7:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0] column_index;
    logic [7:0] key_pressed;
    logic       last_column;
  } result_t;

  localparam int FIELD_LANES = 8;

  localparam logic [7:0] DEBOUNCE_MS_RESET = 8'd0;
  localparam logic [3:0] ROWS_USED_RESET   = 4'd8;
  localparam logic [3:0] COLS_USED_RESET   = 4'd8;

  function automatic logic [3:0] clamp_count(input logic [3:0] v, input logic [3:0] top);
    logic [3:0] r;
    if (v == 4'd0) begin
      r = 4'd1;
    end else if (v > top) begin
      r = top;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/key_matrix_debounce_scanner.sv -----
// Key matrix scanner with per-key debounce. Each item beat carries one scanned
// column: raw active-low row levels and the current 8-bit millisecond time. The
// block keeps a stable pressed bit and a change start time per key, scans
// columns in turn from 0 to cols_used-1 (clamped to 1..COL_DEPTH) and returns
// one result beat per item with the column index, the debounced pressed bits
// (bit r = row r, rows out of use read 0) and a flag on the last column in use.
// A debounce_ms of 0 passes raw levels straight through without touching the
// debounce state. One item is taken every clock cycle while the sink keeps up;
// its result is registered and shows in the cycle after acceptance if the
// result register is free, and otherwise waits in the skid register until the
// beat ahead of it is taken. A two-entry output stage (result register plus
// skid register) sets the back-pressure: item_stall rises only once both hold
// results that the sink has not taken. All key state is cleared by reset.
// Configuration is written through cfg_valid/cfg_ready, always ready.
module key_matrix_debounce_scanner import kmds_pkg::*; #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int LANES     = (MAX_ROWS < FIELD_LANES) ? MAX_ROWS : FIELD_LANES;
  localparam int COL_DEPTH = (MAX_COLS < FIELD_LANES) ? MAX_COLS : FIELD_LANES;
  localparam int COL_W     = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;

  logic [7:0] debounce_ms;
  logic [3:0] rows_used;
  logic [3:0] cols_used;

  logic [2:0] column_pointer;
  logic [LANES-1:0]      stable [COL_DEPTH];
  logic [LANES-1:0][7:0] start  [COL_DEPTH];

  logic [3:0] rows_eff;
  logic [3:0] cols_eff;
  logic [2:0] col;
  logic       last;
  logic [2:0] column_pointer_next;
  logic       item_accept;
  logic       drain;

  logic [LANES-1:0]      stable_next;
  logic [LANES-1:0][7:0] start_next;
  logic [7:0]            key_pressed;
  result_t               result_next;

  logic    skid_valid;
  result_t skid;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_MS_RESET;
      rows_used   <= ROWS_USED_RESET;
      cols_used   <= COLS_USED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE_MS: debounce_ms <= cfg_data;
        CFG_ROWS_USED:   rows_used   <= cfg_data[3:0];
        CFG_COLS_USED:   cols_used   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // column selection
  assign rows_eff = clamp_count(rows_used, 4'(LANES));
  assign cols_eff = clamp_count(cols_used, 4'(COL_DEPTH));
  assign col      = ({1'b0, column_pointer} >= cols_eff) ? 3'd0 : column_pointer;
  assign last     = (({1'b0, col} + 4'd1) >= cols_eff);
  assign column_pointer_next = last ? 3'd0 : 3'(col + 3'd1);

  kmds_debounce #(
    .LANES(LANES)
  ) u_debounce (
    .rows        (rows_eff),
    .debounce_ms (debounce_ms),
    .row_levels  (item.row_levels),
    .now_ms      (item.now_ms),
    .stable_cur  (stable[col[COL_W-1:0]]),
    .start_cur   (start[col[COL_W-1:0]]),
    .stable_next (stable_next),
    .start_next  (start_next),
    .key_pressed (key_pressed)
  );

  assign result_next.column_index = col;
  assign result_next.key_pressed  = key_pressed;
  assign result_next.last_column  = last;

  assign item_stall  = skid_valid;
  assign item_accept = item_valid && !item_stall;
  assign drain       = result_valid && !result_stall;

  // key state
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pointer <= 3'd0;
      for (int c = 0; c < COL_DEPTH; c++) begin
        stable[c] <= '0;
        start[c]  <= '0;
      end
    end else if (item_accept) begin
      column_pointer            <= column_pointer_next;
      stable[col[COL_W-1:0]]    <= stable_next;
      start[col[COL_W-1:0]]     <= start_next;
    end
  end

  // result register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (drain) begin
        skid_valid <= 1'b0;
      end
    end else if (item_accept) begin
      if (result_valid && !drain) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (drain) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (drain) begin
        result <= skid;
      end
    end else if (item_accept) begin
      if (result_valid && !drain) begin
        skid <= result_next;
      end else begin
        result <= result_next;
      end
    end
  end

  a_skid_implies_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid beat held without a result beat");

  a_column_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ({1'b0, result.column_index} < 4'(COL_DEPTH)))
    else $error("result column beyond storage");

  a_wrap_after_last: assert property (@(posedge clk) disable iff (rst)
    (item_accept && last) |=> (column_pointer == 3'd0))
    else $error("column pointer did not wrap after last column");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (item_accept && !last) |=> (column_pointer == 3'($past(col) + 3'd1)))
    else $error("column pointer did not advance");

endmodule

// ----- rtl/core/kmds_debounce.sv -----
module kmds_debounce import kmds_pkg::*; #(
  parameter int LANES = 8
) (
  input  logic [3:0]            rows,
  input  logic [7:0]            debounce_ms,
  input  logic [7:0]            row_levels,
  input  logic [7:0]            now_ms,
  input  logic [LANES-1:0]      stable_cur,
  input  logic [LANES-1:0][7:0] start_cur,
  output logic [LANES-1:0]      stable_next,
  output logic [LANES-1:0][7:0] start_next,
  output logic [7:0]            key_pressed
);

  logic             enabled;
  logic [LANES-1:0] raw;
  logic [LANES-1:0] used;

  assign enabled = (debounce_ms != 8'd0);

  always_comb begin
    stable_next = stable_cur;
    start_next  = start_cur;
    key_pressed = '0;
    for (int r = 0; r < LANES; r++) begin
      raw[r]  = ~row_levels[r];
      used[r] = (rows > 4'(r));
      if (enabled && used[r]) begin
        if (raw[r] == stable_cur[r]) begin
          start_next[r] = now_ms;
        end else if (8'(now_ms - start_cur[r]) >= debounce_ms) begin
          stable_next[r] = raw[r];
          start_next[r]  = now_ms;
        end
        key_pressed[r] = stable_next[r];
      end else begin
        // pass-through when debouncing is off, rows out of use read 0
        key_pressed[r] = used[r] & raw[r];
      end
    end
  end

endmodule

// ----- test/kmds_scan_checker.sv -----
module kmds_scan_checker import kmds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_stall,
  input  item_t      item,
  input  logic       result_valid,
  input  logic       result_stall,
  input  result_t    result,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       leftover_check,
  output int         fail_count,
  output int         outstanding,
  output int         columns_taken,
  output int         results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] debounce_reg;
  logic [3:0] rows_reg;
  logic [3:0] cols_reg;
  int         col_ptr;
  logic       stable[FIELD_LANES * FIELD_LANES];
  logic [7:0] start_ms[FIELD_LANES * FIELD_LANES];

  result_t    expected_q[$];
  int         fail_total = 0;
  int         taken_total = 0;
  int         checked_total = 0;

  assign fail_count      = fail_total;
  assign columns_taken   = taken_total;
  assign results_checked = checked_total;

  initial outstanding = 0;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_total++;
  endtask

  function automatic int lanes_in_use(logic [3:0] count);
    if (count == 4'd0) return 1;
    if (int'(count) > FIELD_LANES) return FIELD_LANES;
    return int'(count);
  endfunction

  function automatic result_t scan_column(item_t it);
    result_t    res;
    int         rows;
    int         cols;
    int         col;
    int         k;
    int         r;
    logic       raw;
    logic       key;
    logic [7:0] age;
    rows = lanes_in_use(rows_reg);
    cols = lanes_in_use(cols_reg);
    col  = (col_ptr >= cols) ? 0 : col_ptr;
    res  = '0;
    for (r = 0; r < rows; r++) begin
      raw = ~it.row_levels[r];
      key = raw;
      if (debounce_reg != 8'd0) begin
        k = col * FIELD_LANES + r;
        if (raw == stable[k]) begin
          start_ms[k] = it.now_ms;
        end else begin
          age = it.now_ms - start_ms[k];
          if (age >= debounce_reg) begin
            stable[k]   = raw;
            start_ms[k] = it.now_ms;
          end
        end
        key = stable[k];
      end
      res.key_pressed[r] = key;
    end
    res.column_index = col[2:0];
    res.last_column  = (col + 1 >= cols);
    col_ptr = res.last_column ? 0 : col + 1;
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      debounce_reg = DEBOUNCE_MS_RESET;
      rows_reg     = ROWS_USED_RESET;
      cols_reg     = COLS_USED_RESET;
      col_ptr      = 0;
      foreach (stable[i]) begin
        stable[i]   = 1'b0;
        start_ms[i] = 8'd0;
      end
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEBOUNCE_MS: debounce_reg = cfg_data;
          CFG_ROWS_USED:   rows_reg = cfg_data[3:0];
          CFG_COLS_USED:   cols_reg = cfg_data[3:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        expected_q.push_back(scan_column(item));
        taken_total++;
      end
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", int'(result), 0);
        end else begin
          want = expected_q.pop_front();
          checked_total++;
          if (result.column_index !== want.column_index)
            report_mismatch("column_index", int'(result.column_index),
                            int'(want.column_index));
          if (result.key_pressed !== want.key_pressed)
            report_mismatch("key_pressed", int'(result.key_pressed),
                            int'(want.key_pressed));
          if (result.last_column !== want.last_column)
            report_mismatch("last_column", int'(result.last_column),
                            int'(want.last_column));
        end
      end
      if (leftover_check && expected_q.size() != 0) begin
        report_mismatch("results never delivered", 0, expected_q.size());
        expected_q.delete();
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

// ----- test/tb.sv -----
module tb import kmds_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 8;
  localparam int KEYS        = FIELD_LANES * FIELD_LANES;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  item_t      item = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = CFG_DEBOUNCE_MS;
  logic [7:0] cfg_data = 8'd0;
  logic       leftover_check = 1'b0;

  int fail_count;
  int outstanding;
  int columns_taken;
  int results_checked;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cfg_writes = 0;

  // stimulus-side picture of the matrix
  int         clock_ms = 0;
  int         scan_col = 0;
  int         cols_now = 8;
  int         deb_now = 0;
  logic       held[KEYS];
  int         bounce_end[KEYS];

  wire beat = (item_valid && !item_stall) || (result_valid && !result_stall) ||
              (cfg_valid && cfg_ready);

  key_matrix_debounce_scanner dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  kmds_scan_checker scan_check (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .leftover_check(leftover_check),
    .fail_count(fail_count),
    .outstanding(outstanding),
    .columns_taken(columns_taken),
    .results_checked(results_checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || beat) quiet = 0;
      else quiet++;
    end
    $display("key_matrix_debounce_scanner regression: fail");
    $finish;
  end

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(cfg_index_t idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
  endtask

  task automatic configure(logic [7:0] deb, logic [7:0] rows, logic [7:0] cols);
    write_reg(CFG_DEBOUNCE_MS, deb);
    write_reg(CFG_ROWS_USED, rows);
    write_reg(CFG_COLS_USED, cols);
    // unmapped index, must be ignored
    write_reg(cfg_index_t'(2'd3), 8'($urandom_range(255)));
    cfg_valid <= 1'b0;
    deb_now  = int'(deb);
    cols_now = (cols[3:0] == 4'd0) ? 1 :
               ((int'(cols[3:0]) > FIELD_LANES) ? FIELD_LANES : int'(cols[3:0]));
  endtask

  task automatic send_item(logic [7:0] levels, logic [7:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{row_levels: levels, now_ms: stamp};
    do @(posedge clk); while (item_stall);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic scan_segment(int count);
    int         n;
    int         r;
    int         k;
    logic [7:0] levels;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(99) < 3) clock_ms += $urandom_range(255);
      else clock_ms += $urandom_range(1);
      if ($urandom_range(7) == 0) begin
        k = scan_col * FIELD_LANES + $urandom_range(FIELD_LANES - 1);
        held[k]       = !held[k];
        bounce_end[k] = clock_ms + $urandom_range(2 * deb_now + 3);
      end
      if ($urandom_range(99) < 15) begin
        levels = 8'($urandom_range(255));
      end else begin
        for (r = 0; r < FIELD_LANES; r++) begin
          k = scan_col * FIELD_LANES + r;
          levels[r] = (clock_ms < bounce_end[k]) ? 1'($urandom_range(1)) : !held[k];
        end
      end
      send_item(levels, clock_ms[7:0]);
      scan_col = (scan_col + 1 >= cols_now) ? 0 : scan_col + 1;
    end
  endtask

  initial begin
    int         phase;
    int         seg;
    logic [7:0] deb;
    foreach (held[i]) begin
      held[i]       = 1'b0;
      bounce_end[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings, raw pass-through, a full frame and a partial one
    send_item(8'h00, 8'h00);
    send_item(8'hFF, 8'hFF);
    send_item(8'h55, 8'h01);
    send_item(8'hAA, 8'h80);
    send_item(8'h7F, 8'h10);
    send_item(8'hFE, 8'h20);
    send_item(8'h80, 8'h30);
    send_item(8'h01, 8'h40);
    send_item(8'h00, 8'h50);
    send_item(8'h00, 8'h51);
    send_item(8'h00, 8'h52);
    // pointer left beyond a shrunk column count
    drain();
    configure(8'd0, 8'd8, 8'd2);
    send_item(8'h0F, 8'h60);
    // zero counts clamp to one
    drain();
    configure(8'd0, 8'd0, 8'd0);
    send_item(8'h00, 8'h61);
    // longest debounce, oversize row count, wrap of the time difference
    drain();
    configure(8'd255, 8'd15, 8'd1);
    send_item(8'h00, 8'h00);
    send_item(8'h00, 8'hFE);
    send_item(8'h00, 8'hFF);
    send_item(8'hFF, 8'h10);
    // shortest debounce
    drain();
    configure(8'd1, 8'd8, 8'd1);
    send_item(8'hFF, 8'h11);
    send_item(8'h00, 8'h11);
    send_item(8'h00, 8'h12);
    // upper data bits of the count registers ignored
    drain();
    configure(8'd3, 8'h84, 8'hF3);
    send_item(8'h00, 8'h20);
    send_item(8'h00, 8'h21);
    send_item(8'h00, 8'h22);

    scan_col = 0;
    for (phase = 0; phase < 3; phase++) begin
      for (seg = 0; seg < 7; seg++) begin
        drain();
        case (phase)
          0: begin send_idle_pct = 21; recv_idle_pct = 61; end
          1: begin send_idle_pct = 61; recv_idle_pct = 21; end
          default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
        case ($urandom_range(9))
          0, 1:    deb = 8'd0;
          2:       deb = 8'd255;
          3:       deb = 8'd1;
          default: deb = 8'($urandom_range(2, 12));
        endcase
        configure(deb, 8'($urandom_range(255)), 8'($urandom_range(255)));
        scan_col = 0;
        scan_segment(95);
      end
    end

    drain();
    leftover_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("scanned %0d column beats, checked %0d result beats, %0d register writes",
             columns_taken, results_checked, cfg_writes);
    $display("debounce off, one ms and 255 ms, clamped counts, pointer past a shrunk frame");
    if (fail_count == 0) begin
      $display("key_matrix_debounce_scanner regression: pass");
    end else begin
      $display("key_matrix_debounce_scanner regression: fail");
    end
    $finish;
  end

endmodule

// ----- key_matrix_debounce_scanner.f -----
rtl/core/kmds_pkg.sv
rtl/core/kmds_debounce.sv
rtl/core/key_matrix_debounce_scanner.sv
test/kmds_scan_checker.sv
test/tb.sv
